// ===== sv/brpq_pkg.sv =====
// shared constants and types for the bucketed priority queue
`timescale 1ns / 1ps
`default_nettype none
package brpq_pkg;
	localparam int NUM_SEGS = 16;
	localparam int SEG_DEPTH = 64;
	localparam int VALUE_BITS = 32;
	localparam int SEG_BITS = $clog2(NUM_SEGS);
	localparam int PTR_BITS = $clog2(SEG_DEPTH);
	localparam int FILL_BITS = $clog2(SEG_DEPTH + 1);
	localparam int ADDR_BITS = SEG_BITS + PTR_BITS;
	localparam int PRIO_BITS = 16;
	localparam int QDEPTH = 2;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_EXTRACTED = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_EXTRACT = 1'b1;

	localparam logic CFG_MIN = 1'b0;
	localparam logic CFG_MAX = 1'b1;

	// classified request handed from front to back
	typedef struct packed {
		logic                  action;
		logic [VALUE_BITS-1:0] value;
		logic [SEG_BITS-1:0]   seg;
	} req_t;
endpackage
`default_nettype wire

// ===== sv/bucketed_relaxed_priority_queue_unit.sv =====
// top level of the bucketed relaxed priority queue
// insert: the front computes the segment with a bit-serial divider before the request is queued
// extract: the value comes from the registered stack memory read (states S_READ, S_HOLD)
// the front takes no new word while dividing; the back takes no new request until its result is taken
// the front takes the next word once its request enters the queue
// arst_n clears fill counts, config to min 0 and max 1023; stack memory needs no clearing
`timescale 1ns / 1ps
`default_nettype none
module bucketed_relaxed_priority_queue_unit import brpq_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        action,
	input  wire logic [31:0]                 item_value,
	input  wire logic signed [15:0]          priority_req,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       status,
	output logic [31:0]                      out_value,
	output logic [3:0]                       segment_used,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_index,
	input  wire logic [15:0]                 cfg_data
);
	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic fr_valid, fr_ready, bk_valid, bk_ready;
	req_t fr_req, bk_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 16'sd0;
			max_q <= 16'sd1023;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MIN: min_q <= cfg_data;
				CFG_MAX: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	brpq_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .item_value(item_value), .priority_req(priority_req),
		.min_prio(min_q), .max_prio(max_q),
		.req_valid(fr_valid), .req_ready(fr_ready), .req(fr_req)
	);

	brpq_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_valid(fr_valid), .push_ready(fr_ready),
		.push_data(fr_req), .pop_valid(bk_valid), .pop_ready(bk_ready),
		.pop_data(bk_req)
	);

	brpq_back u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(bk_valid), .req_ready(bk_ready),
		.req(bk_req), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_value(out_value), .segment_used(segment_used)
	);
endmodule
`default_nettype wire

// ===== sv/brpq_ram.sv =====
// generic ram with one write port and one read port, registered read
`timescale 1ns / 1ps
`default_nettype none
module brpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/brpq_front.sv =====
// front end: accepts words and computes the segment of inserts by serial division
`timescale 1ns / 1ps
`default_nettype none
module brpq_front import brpq_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        action,
	input  wire logic [VALUE_BITS-1:0]       item_value,
	input  wire logic signed [PRIO_BITS-1:0] priority_req,
	input  wire logic signed [PRIO_BITS-1:0] min_prio,
	input  wire logic signed [PRIO_BITS-1:0] max_prio,
	output logic                             req_valid,
	input  wire logic                        req_ready,
	output req_t                             req
);
	localparam int DB = PRIO_BITS + 2;
	localparam int QB = PRIO_BITS + 1;
	localparam int CB = $clog2(QB + 1);

	typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_OUT} state_t;

	state_t                state_q;
	logic                  action_q;
	logic [VALUE_BITS-1:0] value_q;
	logic signed [DB-1:0]  num_q;
	logic signed [DB-1:0]  width_q;
	logic [QB-1:0]         dvd_q;
	logic [QB-1:0]         dvs_q;
	logic [QB-1:0]         rem_q;
	logic [QB-1:0]         quo_q;
	logic                  neg_q;
	logic [CB-1:0]         cnt_q;
	logic [SEG_BITS-1:0]   seg_q;

	logic signed [DB-1:0] span;
	logic signed [DB-1:0] wraw;
	logic [QB:0]          trial;
	logic [QB-1:0]        rem_sh;
	logic signed [QB:0]   sq;

	// span + NUM_SEGS - 1 then truncating divide by a power of two
	always_comb begin
		span = DB'(max_prio) - DB'(min_prio) + DB'(NUM_SEGS - 1);
		if (span < 0) begin
			wraw = -((-span) >>> SEG_BITS);
		end else begin
			wraw = span >>> SEG_BITS;
		end
		rem_sh = {rem_q[QB-2:0], dvd_q[QB-1]};
		trial = {1'b0, rem_sh} - {1'b0, dvs_q};
		sq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	end

	assign in_stall = (state_q != S_IDLE);
	assign req_valid = (state_q == S_OUT);
	assign req = '{action: action_q, value: value_q, seg: seg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						action_q <= action;
						value_q <= item_value;
						num_q <= DB'(priority_req) - DB'(min_prio);
						width_q <= (wraw == '0) ? DB'(1) : wraw;
						state_q <= (action == ACT_EXTRACT) ? S_OUT : S_PREP;
						seg_q <= '0;
					end
				end
				S_PREP: begin
					dvd_q <= QB'(num_q < 0 ? -num_q : num_q);
					dvs_q <= QB'(width_q < 0 ? -width_q : width_q);
					neg_q <= num_q[DB-1] ^ width_q[DB-1];
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CB'(QB);
					state_q <= S_DIV;
				end
				S_DIV: begin
					// one quotient bit per cycle
					if (cnt_q == '0) begin
						if (sq < 0) begin
							seg_q <= '0;
						end else if (sq > (QB+1)'(NUM_SEGS - 1)) begin
							seg_q <= SEG_BITS'(NUM_SEGS - 1);
						end else begin
							seg_q <= SEG_BITS'(sq);
						end
						state_q <= S_OUT;
					end else begin
						dvd_q <= {dvd_q[QB-2:0], 1'b0};
						if (!trial[QB]) begin
							rem_q <= trial[QB-1:0];
							quo_q <= {quo_q[QB-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[QB-2:0], 1'b0};
						end
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_OUT: begin
					if (req_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("front request changed while waiting");
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> in_stall)
		else $error("front accepts during division");
	a_ins_divides: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && in_valid && action == ACT_INSERT |=> state_q == S_PREP)
		else $error("insert skipped division");
`endif
endmodule
`default_nettype wire

// ===== sv/brpq_queue.sv =====
// short fifo between front and back
`timescale 1ns / 1ps
`default_nettype none
module brpq_queue import brpq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  req_t      push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output req_t      pop_data
);
	localparam int PB = $clog2(QDEPTH);

	req_t            buf_q [QDEPTH];
	logic [PB-1:0]   wp_q;
	logic [PB-1:0]   rp_q;
	logic [PB:0]     cnt_q;
	logic            push;
	logic            pop;

	assign push_ready = (cnt_q != (PB+1)'(QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = buf_q[rp_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PB+1)'(push) - (PB+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== sv/brpq_back.sv =====
// back end: fill counts, stack memory and result register
`timescale 1ns / 1ps
`default_nettype none
module brpq_back import brpq_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_ready,
	input  req_t                        req,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [1:0]                  status,
	output logic [VALUE_BITS-1:0]       out_value,
	output logic [3:0]                  segment_used
);
	typedef enum logic [1:0] {S_IDLE, S_READ, S_HOLD} state_t;

	state_t               state_q;
	logic [FILL_BITS-1:0] fill_q [NUM_SEGS];
	logic                 ovalid_q;
	logic                 we;
	logic [ADDR_BITS-1:0] waddr;
	logic [ADDR_BITS-1:0] raddr;
	logic [ADDR_BITS-1:0] raddr_q;
	logic [VALUE_BITS-1:0] rdata;
	logic                 found;
	logic [SEG_BITS-1:0]  best;
	logic                 full;
	logic                 take;

	brpq_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_SEGS * SEG_DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.value),
		.raddr(raddr_q),
		.rdata(rdata)
	);

	// priority pick of lowest non-empty segment
	always_comb begin
		found = 1'b0;
		best = '0;
		for (int i = NUM_SEGS - 1; i >= 0; i--) begin
			if (fill_q[i] != '0) begin
				found = 1'b1;
				best = SEG_BITS'(i);
			end
		end
		full = (fill_q[req.seg] == FILL_BITS'(SEG_DEPTH));
		take = req_valid && req_ready;
		we = take && req.action == ACT_INSERT && !full;
		waddr = {req.seg, PTR_BITS'(fill_q[req.seg])};
		raddr = {best, PTR_BITS'(fill_q[best] - 1'b1)};
	end

	assign req_ready = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovalid_q <= 1'b0;
			for (int i = 0; i < NUM_SEGS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						out_value <= '0;
						if (req.action == ACT_INSERT) begin
							segment_used <= 4'(req.seg);
							status <= full ? ST_FULL : ST_INSERTED;
							if (!full) begin
								fill_q[req.seg] <= fill_q[req.seg] + 1'b1;
							end
							ovalid_q <= 1'b1;
						end else if (!found) begin
							segment_used <= '0;
							status <= ST_EMPTY;
							ovalid_q <= 1'b1;
						end else begin
							segment_used <= 4'(best);
							status <= ST_EXTRACTED;
							fill_q[best] <= fill_q[best] - 1'b1;
							raddr_q <= raddr;
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_HOLD;
				S_HOLD: begin
					out_value <= rdata;
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> fill_q[req.seg] <= FILL_BITS'(SEG_DEPTH))
		else $error("fill count overflow");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !full)
		else $error("write into full segment");
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HOLD |=> out_valid && status == ST_EXTRACTED)
		else $error("extract result missing");
`endif
endmodule
`default_nettype wire
